// File: rtl/core/signed_binary_to_decimal_digits_core_macros.svh
// Assertion macros shared by the checker of the signed decimal digit converter.
`ifndef SIGNED_BINARY_TO_DECIMAL_DIGITS_CORE_MACROS_SVH
`define SIGNED_BINARY_TO_DECIMAL_DIGITS_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SBDD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SBDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sbdd_pkg.sv
// Package with widths and shared types of the signed decimal digit converter.
`default_nettype none

package sbdd_pkg;

    // Width of the two's complement word that is converted.
    localparam int WORD_BITS = 32;

    // Width of one decimal digit.
    localparam int DIGIT_W = 4;

    // Decimal digits needed for the largest magnitude, 2^(WORD_BITS-1).
    localparam int NUM_DIGITS = ((WORD_BITS - 1) * 30103) / 100000 + 1;

    // Width of the packed digit register.
    localparam int BCD_W = NUM_DIGITS * DIGIT_W;

    // Counter widths: conversion steps and digits still to be sent.
    localparam int STEP_W = $clog2(WORD_BITS + 1);
    localparam int CNT_W  = $clog2(NUM_DIGITS + 1);

    // Start of one conversion in the shift-and-add-3 unit.
    typedef struct packed {
        logic                 start;
        logic [WORD_BITS-1:0] mag;
    } conv_ctrl_t;

    // Hand-over of a finished digit set to the digit sender.
    typedef struct packed {
        logic             load;
        logic             negative;
        logic [BCD_W-1:0] bcd;
    } emit_load_t;

endpackage

`default_nettype wire

// File: rtl/core/sbdd_if.sv
// Channel interfaces for input words and output digits.
`default_nettype none

// One transaction carries one two's complement word.
interface sbdd_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

// One transaction carries one decimal digit with its sign and end marker.
interface sbdd_digit_if;
    logic                        valid;
    logic                        ready;
    logic [sbdd_pkg::DIGIT_W-1:0] digit;
    logic                        negative;
    logic                        last;

    modport source (output valid, output digit, output negative, output last, input ready);
    modport sink   (input valid, input digit, input negative, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sbdd_dabble.sv
// Shift-and-add-3 unit that turns a binary magnitude into packed decimal digits.
`default_nettype none

module sbdd_dabble (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire sbdd_pkg::conv_ctrl_t       ctrl,
    output logic                            done,
    output logic [sbdd_pkg::BCD_W-1:0]      bcd
);

    logic [sbdd_pkg::BCD_W-1:0]     bcd_reg;
    logic [sbdd_pkg::BCD_W-1:0]     bcd_next;
    logic [sbdd_pkg::BCD_W-1:0]     adj;
    logic [sbdd_pkg::WORD_BITS-1:0] bin_reg;
    logic [sbdd_pkg::WORD_BITS-1:0] bin_next;
    logic [sbdd_pkg::STEP_W-1:0]    step_reg;
    logic [sbdd_pkg::STEP_W-1:0]    step_next;

    // Each digit of five or more gets three added before the shift.
    always_comb
    begin
        for (int i = 0; i < sbdd_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*sbdd_pkg::DIGIT_W +: sbdd_pkg::DIGIT_W] >= 4'd5)
            begin
                adj[i*sbdd_pkg::DIGIT_W +: sbdd_pkg::DIGIT_W] =
                    bcd_reg[i*sbdd_pkg::DIGIT_W +: sbdd_pkg::DIGIT_W] + 4'd3;
            end
            else
            begin
                adj[i*sbdd_pkg::DIGIT_W +: sbdd_pkg::DIGIT_W] =
                    bcd_reg[i*sbdd_pkg::DIGIT_W +: sbdd_pkg::DIGIT_W];
            end
        end
    end

    // One binary bit moves into the digit register per step.
    always_comb
    begin
        bcd_next  = bcd_reg;
        bin_next  = bin_reg;
        step_next = step_reg;
        if (ctrl.start)
        begin
            bcd_next  = '0;
            bin_next  = ctrl.mag;
            step_next = sbdd_pkg::STEP_W'(sbdd_pkg::WORD_BITS);
        end
        else if (step_reg != '0)
        begin
            bcd_next  = {adj[sbdd_pkg::BCD_W-2:0], bin_reg[sbdd_pkg::WORD_BITS-1]};
            bin_next  = {bin_reg[sbdd_pkg::WORD_BITS-2:0], 1'b0};
            step_next = step_reg - sbdd_pkg::STEP_W'(1);
        end
    end

    // The step counter is control state; the data registers need no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        bin_reg <= bin_next;
    end

    assign done = (step_reg == '0);
    assign bcd  = bcd_reg;

endmodule

`default_nettype wire

// File: rtl/core/sbdd_emit.sv
// Digit sender: drops leading zeros and sends digits most significant first.
`default_nettype none

module sbdd_emit (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sbdd_pkg::emit_load_t  ld,
    output logic                       busy,
    sbdd_digit_if.source               digits
);

    logic [sbdd_pkg::BCD_W-1:0]   bcd_reg;
    logic [sbdd_pkg::CNT_W-1:0]   cnt_reg;
    logic                         active_reg;
    logic                         started_reg;
    logic                         neg_reg;
    logic                         valid_reg;
    logic [sbdd_pkg::DIGIT_W-1:0] digit_reg;
    logic                         negative_reg;
    logic                         last_reg;

    logic [sbdd_pkg::DIGIT_W-1:0] top_digit;
    logic                         final_digit;
    logic                         advance;
    logic                         send;

    assign top_digit   = bcd_reg[sbdd_pkg::BCD_W-1 -: sbdd_pkg::DIGIT_W];
    assign final_digit = (cnt_reg == sbdd_pkg::CNT_W'(1));
    assign advance     = active_reg && (!valid_reg || digits.ready);
    assign send        = started_reg || (top_digit != '0) || final_digit;

    // Control state of the sender and the valid flag of the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            started_reg <= 1'b0;
            cnt_reg     <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (ld.load)
            begin
                active_reg  <= 1'b1;
                started_reg <= 1'b0;
                cnt_reg     <= sbdd_pkg::CNT_W'(sbdd_pkg::NUM_DIGITS);
            end
            else if (advance)
            begin
                cnt_reg <= cnt_reg - sbdd_pkg::CNT_W'(1);
                if (send)
                begin
                    started_reg <= 1'b1;
                end
                if (final_digit)
                begin
                    active_reg <= 1'b0;
                end
            end

            if (advance)
            begin
                valid_reg <= send;
            end
            else if (digits.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Digit shift register and output payload.
    always_ff @(posedge clk)
    begin
        if (ld.load)
        begin
            bcd_reg <= ld.bcd;
            neg_reg <= ld.negative;
        end
        else if (advance)
        begin
            bcd_reg <= {bcd_reg[sbdd_pkg::BCD_W-sbdd_pkg::DIGIT_W-1:0],
                        {sbdd_pkg::DIGIT_W{1'b0}}};
        end

        if (advance && send)
        begin
            digit_reg    <= top_digit;
            negative_reg <= neg_reg;
            last_reg     <= final_digit;
        end
    end

    assign busy            = active_reg;
    assign digits.valid    = valid_reg;
    assign digits.digit    = digit_reg;
    assign digits.negative = negative_reg;
    assign digits.last     = last_reg;

endmodule

`default_nettype wire

// File: rtl/core/signed_binary_to_decimal_digits_core.sv
// Top level of the signed binary to decimal digit converter.
// The first digit is sent once the shift-and-add-3 loop is done, the digits have
// gone to the sender and its leading zeros are skipped; one digit follows per cycle
// after that while the receiver is ready. A new word is taken once the previous one
// went to the sender, so its conversion overlaps the drain of the previous digits;
// a stalled receiver delays the hand-over. Reset clears all control state.
`default_nettype none

module signed_binary_to_decimal_digits_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    sbdd_word_if.sink     words,
    sbdd_digit_if.source  digits
);

    typedef enum logic {
        ST_IDLE,
        ST_CONV
    } state_t;

    state_t                         state_reg;
    logic                           ready_reg;
    logic                           neg_reg;
    logic [sbdd_pkg::WORD_BITS-1:0] w;
    logic                           accept;
    logic                           conv_done;
    logic                           emit_busy;
    logic [sbdd_pkg::BCD_W-1:0]     bcd;
    sbdd_pkg::conv_ctrl_t           conv_ctrl;
    sbdd_pkg::emit_load_t           emit_ld;

    assign words.ready = ready_reg;
    assign accept      = words.valid && ready_reg;
    assign w           = sbdd_pkg::WORD_BITS'(words.word);

    // A negative word is negated to its magnitude when it is taken.
    always_comb
    begin
        conv_ctrl.start = accept;
        if (w[sbdd_pkg::WORD_BITS-1])
        begin
            conv_ctrl.mag = ~w + sbdd_pkg::WORD_BITS'(1);
        end
        else
        begin
            conv_ctrl.mag = w;
        end
    end

    // The finished digits go to the sender once it has drained the previous run.
    assign emit_ld.load     = (state_reg == ST_CONV) && conv_done && !emit_busy;
    assign emit_ld.negative = neg_reg;
    assign emit_ld.bcd      = bcd;

    // Sequencer with the registered ready flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_CONV;
                        ready_reg <= 1'b0;
                    end
                end
                ST_CONV:
                begin
                    if (emit_ld.load)
                    begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    // The sign is kept for the whole run.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            neg_reg <= w[sbdd_pkg::WORD_BITS-1];
        end
    end

    sbdd_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (conv_ctrl),
        .done  (conv_done),
        .bcd   (bcd)
    );

    sbdd_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .ld     (emit_ld),
        .busy   (emit_busy),
        .digits (digits)
    );

endmodule

`default_nettype wire

// File: rtl/core/sbdd_checker.sv
// Port checker of the signed decimal digit converter and its bind.
`default_nettype none

`include "signed_binary_to_decimal_digits_core_macros.svh"

module sbdd_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [sbdd_pkg::DIGIT_W-1:0] out_digit,
    input wire logic                         out_negative,
    input wire logic                         out_last
);

    // A stalled output transaction keeps its valid flag.
    `SBDD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output valid dropped while stalled")

    // The block takes no second word while the first is being converted.
    `SBDD_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "ready stayed high after a word was taken")

    // The sign flag does not change inside one run of digits.
    `SBDD_ASSERT_NEXT(a_sign_steady, out_valid && !out_last, $stable(out_negative), "sign changed within a run")

    // Every digit sent is a decimal digit.
    `SBDD_ASSERT_SAME(a_digit_range, out_valid, out_digit <= 4'd9, "digit above nine")

endmodule

bind signed_binary_to_decimal_digits_core sbdd_checker u_sbdd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (words.valid),
    .in_ready     (words.ready),
    .out_valid    (digits.valid),
    .out_ready    (digits.ready),
    .out_digit    (digits.digit),
    .out_negative (digits.negative),
    .out_last     (digits.last)
);

`default_nettype wire

// File: tb/sv/tb_signed_binary_to_decimal_digits_core.sv
// Self-checking testbench of the signed binary to decimal digit converter.
`default_nettype none

module tb_signed_binary_to_decimal_digits_core;

    // One expected digit transaction.
    typedef struct packed {
        logic [sbdd_pkg::DIGIT_W-1:0] digit;
        logic                         negative;
        logic                         last;
    } digit_t;

    // Holds the digits that the accepted words must produce, oldest first.
    class digit_scoreboard;
        digit_t expected_digits[$];
        int     errors;

        // Converts one accepted word into its signed decimal digits.
        function void note_word(logic [31:0] w);
            logic                         negative;
            logic [63:0]                  mask;
            logic [63:0]                  mag;
            logic [sbdd_pkg::DIGIT_W-1:0] decimal[$];
            digit_t                       d;
            int                           k;
            mask     = {64{1'b1}} >> (64 - sbdd_pkg::WORD_BITS);
            mag      = 64'(w) & mask;
            negative = mag[sbdd_pkg::WORD_BITS-1];
            // The most negative word wraps to itself, which as unsigned is its magnitude.
            if (negative)
                mag = (~mag + 64'd1) & mask;
            do
            begin
                decimal.push_front(sbdd_pkg::DIGIT_W'(mag % 64'd10));
                mag = mag / 64'd10;
            end
            while (mag != 64'd0);
            for (k = 0; k < decimal.size(); k++)
            begin
                d.digit    = decimal[k];
                d.negative = negative;
                d.last     = (k == decimal.size() - 1);
                expected_digits.push_back(d);
            end
        endfunction

        // Compares one accepted digit with the oldest expectation.
        function void check_digit(logic [sbdd_pkg::DIGIT_W-1:0] digit, logic negative,
                                  logic last);
            digit_t want;
            if (expected_digits.size() == 0)
            begin
                $error("unexpected digit transaction: digit %0d negative %0b last %0b",
                       digit, negative, last);
                errors++;
                return;
            end
            want = expected_digits.pop_front();
            if (digit !== want.digit)
            begin
                $error("digit: expected %0d, actual %0d", want.digit, digit);
                errors++;
            end
            if (negative !== want.negative)
            begin
                $error("negative: expected %0b, actual %0b", want.negative, negative);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_digits.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;

    sbdd_word_if  word_ch ();
    sbdd_digit_if digit_ch ();

    digit_scoreboard sb = new();

    signed_binary_to_decimal_digits_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .words  (word_ch),
        .digits (digit_ch)
    );

    // Free-running clock with a period of 10.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // All inputs start known; reset is held low at the start and released at a falling edge.
    initial
    begin
        rst_n          = 1'b0;
        word_ch.valid  = 1'b0;
        word_ch.word   = '0;
        digit_ch.ready = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // The receiver stalls at random once reset is released.
    always @(negedge clk)
    begin
        if (rst_n)
            digit_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Every accepted digit transaction is checked at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && digit_ch.valid && digit_ch.ready)
            sb.check_digit(digit_ch.digit, digit_ch.negative, digit_ch.last);
    end

    // Offers one word after a random gap and holds it until it is accepted.
    task automatic push_word(input logic [31:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            word_ch.valid = 1'b0;
            @(negedge clk);
        end
        word_ch.valid = 1'b1;
        word_ch.word  = w;
        do
            @(posedge clk);
        while (!word_ch.ready);
        sb.note_word(w);
        @(negedge clk);
    endtask

    function automatic longint power_of_ten(input int k);
        longint p;
        p = 1;
        repeat (k) p = p * 10;
        return p;
    endfunction

    // Random word: full range, a random digit count, a decade edge, or near the extremes.
    function automatic logic [31:0] pick_word();
        logic [31:0] mag;
        longint      top;
        int          ndig;
        case ($urandom_range(3))
            0: mag = $urandom;
            1:
            begin
                ndig = $urandom_range(1, 10);
                top  = power_of_ten(ndig) - 1;
                if (top > 64'd2147483647)
                    top = 64'd2147483647;
                mag = $urandom_range(32'(top), 32'(power_of_ten(ndig - 1)));
            end
            2: mag = 32'(power_of_ten($urandom_range(9))) - $urandom_range(1);
            default:
            begin
                if ($urandom_range(1))
                    return 32'h8000_0000 + $urandom_range(15);
                mag = 32'h7FFF_FFFF - $urandom_range(15);
            end
        endcase
        return $urandom_range(1) ? (~mag + 32'd1) : mag;
    endfunction

    // Directed words: zero, signs, decade edges, both extremes and alternating bits.
    logic [31:0] directed_words[18] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99999,
        32'd999999999, -32'sd999999999, 32'd1000000000, -32'sd1000000000,
        32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
        32'h5555_5555, 32'hAAAA_AAAA, 32'd4294967286
    };

    // Idle percentages of sender and receiver, one pair per random phase.
    int phase_send[4] = '{0, 77, 0, 11};
    int phase_recv[4] = '{0, 0, 77, 11};

    initial
    begin
        int p;
        int n;
        wait (rst_n === 1'b1);
        @(negedge clk);
        foreach (directed_words[i])
            push_word(directed_words[i]);
        for (p = 0; p < 4; p++)
        begin
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_recv[p];
            for (n = 0; n < 38; n++)
                push_word(pick_word());
        end
        word_ch.valid = 1'b0;
        // Drain with a free receiver, then keep watching for stray digits.
        recv_stall_pct = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (2 * (sbdd_pkg::WORD_BITS + 3 + sbdd_pkg::NUM_DIGITS)) @(posedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog for a run that hangs.
    initial
    begin
        #6000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl/core
rtl/core/sbdd_pkg.sv
rtl/core/sbdd_if.sv
rtl/core/sbdd_dabble.sv
rtl/core/sbdd_emit.sv
rtl/core/signed_binary_to_decimal_digits_core.sv
rtl/core/sbdd_checker.sv
tb/sv/tb_signed_binary_to_decimal_digits_core.sv
